// ===== design/utf8_latin_case_converter_core_defines.svh =====
// Assertion macros for the UTF-8 Latin case converter checker.
// Used by ulcc_checker.sv; expects clk_i and rst_ni in scope.
`ifndef UTF8_LATIN_CASE_CONVERTER_CORE_DEFINES_SVH
`define UTF8_LATIN_CASE_CONVERTER_CORE_DEFINES_SVH

// Checked outside reset only.
`define ULCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ULCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/ulcc_pkg.sv =====
// Shared types, constants and case mapping functions for the UTF-8
// Latin case converter. No dependencies.
package ulcc_pkg;

  localparam int unsigned MaxRes = 4;

  localparam logic [7:0] LeadMin   = 8'h80;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContBits  = 8'h80;
  localparam logic [8:0] CpDotlessI = 9'h131;
  localparam logic [8:0] CpKra      = 9'h138;
  localparam logic [8:0] CpApostN   = 9'h149;

  // Results of one item: up to four bytes, a count and the string end flag
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   str_last;
  } res_t;

  // Lower to upper within U+00C0..U+017F, zero when there is no pair
  function automatic logic [8:0] up_map(input logic [8:0] c);
    logic [8:0] r;
    r = '0;
    if (c >= 9'h0E0 && c <= 9'h0FE && c != 9'h0F7) r = c - 9'h020;
    else if (c == 9'h0FF) r = 9'h178;
    else if (c >= 9'h101 && c <= 9'h12F && c[0]) r = c - 9'h001;
    else if (c >= 9'h133 && c <= 9'h137 && c[0]) r = c - 9'h001;
    else if (c >= 9'h13A && c <= 9'h148 && !c[0]) r = c - 9'h001;
    else if (c >= 9'h14B && c <= 9'h177 && c[0]) r = c - 9'h001;
    else if (c >= 9'h17A && c <= 9'h17E && !c[0]) r = c - 9'h001;
    return r;
  endfunction

  // Upper to lower within U+00C0..U+017F, zero when there is no pair
  function automatic logic [8:0] down_map(input logic [8:0] u);
    logic [8:0] r;
    r = '0;
    if (u >= 9'h0C0 && u <= 9'h0DE && u != 9'h0D7) r = u + 9'h020;
    else if (u == 9'h178) r = 9'h0FF;
    else if (u >= 9'h100 && u <= 9'h12E && !u[0]) r = u + 9'h001;
    else if (u >= 9'h132 && u <= 9'h136 && !u[0]) r = u + 9'h001;
    else if (u >= 9'h139 && u <= 9'h147 && u[0]) r = u + 9'h001;
    else if (u >= 9'h14A && u <= 9'h176 && !u[0]) r = u + 9'h001;
    else if (u >= 9'h179 && u <= 9'h17D && u[0]) r = u + 9'h001;
    return r;
  endfunction

endpackage

// ===== design/ulcc_conv.sv =====
// Group tracking and case conversion for one byte per beat.
// Depends on ulcc_pkg (res_t, up_map, down_map).
module ulcc_conv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  input  logic            upcase_i,
  output ulcc_pkg::res_t  res_o
);
  import ulcc_pkg::*;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      held_count_q, held_count_d;
  logic [2:0]      glen_q, glen_d;

  logic [3:0][7:0] g;
  logic [7:0]      asc;
  logic [2:0]      lead_len;
  logic [2:0]      grp_cnt;
  logic [8:0]      cp, mapped;
  logic            pair_ok;

  // Bytes of the open group followed by this byte
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g[i] = (2'(i) < held_count_q) ? held_q[i] : byte_i;
    end
    g[3] = byte_i;
  end

  assign grp_cnt = {1'b0, held_count_q} + 3'd1;

  // ASCII letter conversion
  always_comb begin
    asc = byte_i;
    if (upcase_i && byte_i >= 8'h61 && byte_i <= 8'h7A) asc = byte_i - 8'h20;
    else if (!upcase_i && byte_i >= 8'h41 && byte_i <= 8'h5A) asc = byte_i + 8'h20;
  end

  // Group length from the lead byte
  always_comb begin
    if (byte_i < Lead3Min)      lead_len = 3'd2;
    else if (byte_i < Lead4Min) lead_len = 3'd3;
    else                        lead_len = 3'd4;
  end

  // Two byte code point lookup
  assign pair_ok = (held_count_q == 2'd1) && (held_q[0] >= 8'hC3) && (held_q[0] <= 8'hC5)
                   && ((byte_i & ContMask) == ContBits);
  assign cp      = {held_q[0][2:0], byte_i[5:0]};
  assign mapped  = upcase_i ? up_map(cp) : down_map(cp);

  // Next state and results
  always_comb begin
    held_d         = held_q;
    held_count_d   = held_count_q;
    glen_d         = glen_q;
    res_o.bytes    = g;
    res_o.cnt      = grp_cnt;
    res_o.str_last = last_i;

    if (held_count_q == 2'd0) begin
      if (byte_i < LeadMin) begin
        res_o.bytes[0] = asc;
        res_o.cnt      = 3'd1;
      end else begin
        held_d[0]    = byte_i;
        held_count_d = 2'd1;
        glen_d       = lead_len;
        if (last_i) begin
          held_count_d = 2'd0;
          glen_d       = 3'd1;
        end else begin
          res_o.cnt = 3'd0;
        end
      end
    end else if (grp_cnt >= glen_q) begin
      // group complete: replace if it is a known pair
      held_count_d = 2'd0;
      glen_d       = 3'd1;
      if (pair_ok) begin
        if (upcase_i && cp == CpDotlessI) begin
          res_o.bytes[0] = 8'h49;
          res_o.cnt      = 3'd1;
        end else if (upcase_i && cp == CpKra) begin
          res_o.bytes[0] = 8'h4B;
          res_o.cnt      = 3'd1;
        end else if (upcase_i && cp == CpApostN) begin
          res_o.bytes[0] = 8'hCA;
          res_o.bytes[1] = 8'hBC;
          res_o.bytes[2] = 8'h4E;
          res_o.cnt      = 3'd3;
        end else if (mapped != 9'd0) begin
          res_o.bytes[0] = 8'hC0 | {5'd0, mapped[8:6]};
          res_o.bytes[1] = 8'h80 | {2'd0, mapped[5:0]};
          res_o.cnt      = 3'd2;
        end
      end
    end else begin
      // still collecting; a string end flushes the partial group
      for (int i = 0; i < 3; i++) begin
        if (2'(i) == held_count_q) held_d[i] = byte_i;
      end
      held_count_d = held_count_q + 2'd1;
      if (last_i) begin
        held_count_d = 2'd0;
        glen_d       = 3'd1;
      end else begin
        res_o.cnt = 3'd0;
      end
    end
  end

  // Group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
      glen_q       <= 3'd1;
    end else if (fire_i) begin
      held_count_q <= held_count_d;
      glen_q       <= glen_d;
    end
  end

  // Held bytes carry no reset
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== design/ulcc_outbuf.sv =====
// Result register that hands out up to four bytes, one per beat.
// Depends on ulcc_pkg (res_t, MaxRes).
module ulcc_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  ulcc_pkg::res_t  res_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            string_end_o
);
  import ulcc_pkg::*;

  logic [MaxRes-1:0][7:0] bytes_q;
  logic [2:0]             rem_q;
  logic [1:0]             pos_q;
  logic                   str_q;
  logic                   out_fire;

  assign out_valid_o  = (rem_q != 3'd0);
  assign out_fire     = out_valid_o && out_ready_i;
  assign free_o       = (rem_q == 3'd0) || (rem_q == 3'd1 && out_ready_i);
  assign out_byte_o   = bytes_q[pos_q];
  assign run_last_o   = (rem_q == 3'd1);
  assign string_end_o = (rem_q == 3'd1) && str_q;

  // Remaining count and read position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      pos_q <= 2'd0;
    end else if (load_i) begin
      rem_q <= res_i.cnt;
      pos_q <= 2'd0;
    end else if (out_fire) begin
      rem_q <= rem_q - 3'd1;
      pos_q <= pos_q + 2'd1;
    end
  end

  // Result bytes
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
      str_q   <= res_i.str_last;
    end
  end

endmodule

// ===== design/utf8_latin_case_converter_core.sv =====
// Top level of the UTF-8 Latin-1 / Latin Extended-A case converter.
// Depends on ulcc_pkg, ulcc_conv and ulcc_outbuf.
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o  in_byte_i, string_last_i
//   out       output     out_valid_o/out_ready_i out_byte_o, run_last_o, string_end_o
//   cfg       input      cfg_we_i               cfg_upcase_i
//
// One input beat per cycle while each byte yields at most one result and the output
// is not stalled; an item yielding several bytes holds the single-byte output port
// until all its bytes have gone out. Each byte passes the input register, then its
// result the result register. Reset clears the group state and selects upper case.
// Output stalls back up through the result register into the input register.
module utf8_latin_case_converter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_upcase_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_end_o
);
  import ulcc_pkg::*;

  logic       upcase_q;
  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_last_q;
  logic       buf_free;
  logic       proc_fire;
  logic       in_fire;
  res_t       res;

  assign proc_fire  = inq_valid_q && buf_free;
  assign in_ready_o = !inq_valid_q || buf_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upcase_q <= 1'b1;
    end else if (cfg_we_i) begin
      upcase_q <= cfg_upcase_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_fire) begin
      inq_valid_q <= 1'b1;
    end else if (proc_fire) begin
      inq_valid_q <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_byte_q <= in_byte_i;
      inq_last_q <= string_last_i;
    end
  end

  ulcc_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (proc_fire),
    .byte_i   (inq_byte_q),
    .last_i   (inq_last_q),
    .upcase_i (upcase_q),
    .res_o    (res)
  );

  ulcc_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (proc_fire),
    .res_i        (res),
    .free_o       (buf_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

endmodule

// ===== design/ulcc_checker.sv =====
// Port-level checks on the output channel of the case converter core.
// Depends on utf8_latin_case_converter_core_defines.svh; bound to the top level.
`include "utf8_latin_case_converter_core_defines.svh"

module ulcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       string_end_o
);

  // nothing leaves while in reset
  `ULCC_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")

  // a stalled beat holds
  `ULCC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o), "stalled output beat changed")

  // end of string only on the last byte of a run
  `ULCC_ASSERT(a_end_on_run_last, out_valid_o && string_end_o |-> run_last_o, "string end without run last")

  // the rest of a run is ready in the next cycle
  `ULCC_ASSERT(a_run_continues, out_valid_o && !run_last_o |=> out_valid_o, "run broken before its last byte")

endmodule

bind utf8_latin_case_converter_core ulcc_checker u_ulcc_checker (.*);

// ===== tb/utf8_latin_case_converter_core_tb.sv =====
// Self-checking testbench for utf8_latin_case_converter_core: directed and random
// UTF-8 text in both case directions, checked beat by beat against a local predictor.
// Depends on ulcc_pkg and the converter RTL.
module utf8_latin_case_converter_core_tb;
  import ulcc_pkg::*;

  localparam int StallLimit = 1000;
  localparam int IdlePct    = 22;
  localparam int Settle     = 8;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ob;
    logic       run_last;
    logic       str_end;
  } out_beat_t;

  logic       clk_i;
  logic       rst_ni         = 1'b1;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_upcase_i   = 1'b1;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i      = 8'h20;
  logic       string_last_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       string_end_o;

  text_beat_t text_q[$];     // bytes waiting to be driven
  out_beat_t  case_out_q[$]; // predicted output bytes
  logic [7:0] str_buf[$];    // string under construction

  // Predictor state
  logic       conv_up  = 1'b1;
  logic [7:0] held_q[3];
  int         held_n   = 0;
  int         grp_len  = 1;

  logic in_taken  = 1'b0;
  bit   calm      = 1'b0;
  int   n_err     = 0;
  int   stall_cnt = 0;

  utf8_latin_case_converter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_upcase_i  (cfg_upcase_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .string_last_i (string_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .string_end_o  (string_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Upper-case Latin Extended-A letters: the lower partner is the next code point
  function automatic bit is_ext_upper(input logic [8:0] u);
    if (u >= 9'h100 && u <= 9'h12E) return !u[0];
    if (u >= 9'h132 && u <= 9'h136) return !u[0];
    if (u >= 9'h139 && u <= 9'h147) return u[0];
    if (u >= 9'h14A && u <= 9'h176) return !u[0];
    if (u >= 9'h179 && u <= 9'h17D) return u[0];
    return 1'b0;
  endfunction

  // Upper partner of a lower-case code point, zero if none
  function automatic logic [8:0] upper_of(input logic [8:0] cp);
    if (cp == 9'h0FF) return 9'h178;
    if (cp >= 9'h0E0 && cp <= 9'h0FE) return (cp == 9'h0F7) ? 9'h000 : cp - 9'h020;
    if (is_ext_upper(cp - 9'h001)) return cp - 9'h001;
    return 9'h000;
  endfunction

  // Lower partner of an upper-case code point, zero if none
  function automatic logic [8:0] lower_of(input logic [8:0] cp);
    if (cp == 9'h178) return 9'h0FF;
    if (cp >= 9'h0C0 && cp <= 9'h0DE) return (cp == 9'h0D7) ? 9'h000 : cp + 9'h020;
    if (is_ext_upper(cp)) return cp + 9'h001;
    return 9'h000;
  endfunction

  // Advance the predictor by one accepted byte and queue the bytes it yields
  task automatic convert_beat(input logic [7:0] b, input logic last);
    logic [7:0] res[$];
    logic [7:0] grp[4];
    logic [8:0] cp;
    logic [8:0] m;
    int         n;
    m = '0;
    if (held_n == 0) begin
      if (b < LeadMin) begin
        if (conv_up && b >= 8'h61 && b <= 8'h7A) res.push_back(b - 8'h20);
        else if (!conv_up && b >= 8'h41 && b <= 8'h5A) res.push_back(b + 8'h20);
        else res.push_back(b);
      end else begin
        grp_len   = (b < Lead3Min) ? 2 : (b < Lead4Min) ? 3 : 4;
        held_q[0] = b;
        held_n    = 1;
      end
    end else if (held_n + 1 >= grp_len) begin
      n = held_n + 1;
      for (int i = 0; i < held_n; i++) grp[i] = held_q[i];
      grp[held_n] = b;
      // only a well-formed two-byte group in U+00C0..U+017F can be replaced
      if (n == 2 && grp[0] >= 8'hC3 && grp[0] <= 8'hC5 && grp[1][7:6] == 2'b10) begin
        cp = {grp[0][2:0], grp[1][5:0]};
        if (conv_up && cp == CpDotlessI) res.push_back(8'h49);
        else if (conv_up && cp == CpKra) res.push_back(8'h4B);
        else if (conv_up && cp == CpApostN) begin
          res.push_back(8'hCA);
          res.push_back(8'hBC);
          res.push_back(8'h4E);
        end else m = conv_up ? upper_of(cp) : lower_of(cp);
        if (m != 0) begin
          res.push_back(8'hC0 | {5'd0, m[8:6]});
          res.push_back(8'h80 | {2'd0, m[5:0]});
        end
      end
      if (res.size() == 0) for (int i = 0; i < n; i++) res.push_back(grp[i]);
      held_n  = 0;
      grp_len = 1;
    end else begin
      held_q[held_n] = b;
      held_n++;
    end
    // group cut off by the end of the string goes out as is
    if (last && held_n > 0) begin
      for (int i = 0; i < held_n; i++) res.push_back(held_q[i]);
      held_n  = 0;
      grp_len = 1;
    end
    for (int i = 0; i < res.size(); i++)
      case_out_q.push_back('{ob: res[i], run_last: i == res.size() - 1,
                             str_end: last && i == res.size() - 1});
  endtask

  // Input side: predict on every accepted beat
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) convert_beat(in_byte_i, string_last_i);
  end

  // Input driver: next byte once the current one is gone, with random gaps
  always @(negedge clk_i) begin
    text_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (text_q.size() != 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
        nxt = text_q.pop_front();
        in_valid_i    <= 1'b1;
        in_byte_i     <= nxt.b;
        string_last_i <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && (calm || $urandom_range(0, 99) >= IdlePct);
  end

  // Output checker
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (case_out_q.size() == 0) begin
        $error("unexpected output beat: out_byte %02h", out_byte_o);
        n_err++;
      end else begin
        want = case_out_q.pop_front();
        if (out_byte_o !== want.ob) begin
          $error("out_byte: expected %02h, got %02h", want.ob, out_byte_o);
          n_err++;
        end
        if (run_last_o !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last_o);
          n_err++;
        end
        if (string_end_o !== want.str_end) begin
          $error("string_end: expected %0b, got %0b", want.str_end, string_end_o);
          n_err++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("utf8_latin_case_converter_core test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Move the string buffer into the send queue, last flag on its final byte
  task automatic flush_str();
    for (int i = 0; i < str_buf.size(); i++)
      text_q.push_back('{b: str_buf[i], last: i == str_buf.size() - 1});
    str_buf.delete();
  endtask

  // One random string: mostly well-formed characters, some noise and cut-off tails
  task automatic emit_string();
    int         nchars;
    int         kind;
    int         glen;
    logic [7:0] lead;
    nchars = $urandom_range(1, 10);
    for (int i = 0; i < nchars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        case ($urandom_range(0, 2))
          0:       str_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
          1:       str_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
          default: str_buf.push_back(8'($urandom_range(1, 127)));
        endcase
      end else if (kind < 65) begin
        str_buf.push_back(8'($urandom_range(8'hC3, 8'hC5)));
        str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 70) begin
        // letters with special upper forms, plus y-diaeresis pair
        case ($urandom_range(0, 4))
          0:       str_buf.push_back(8'hC4);
          1:       str_buf.push_back(8'hC4);
          2:       str_buf.push_back(8'hC5);
          3:       str_buf.push_back(8'hC3);
          default: str_buf.push_back(8'hC5);
        endcase
        case (str_buf[str_buf.size() - 1])
          8'hC4:   str_buf.push_back($urandom_range(0, 1) ? 8'hB1 : 8'hB8);
          8'hC3:   str_buf.push_back(8'hBF);
          default: str_buf.push_back($urandom_range(0, 1) ? 8'h89 : 8'hB8);
        endcase
      end else if (kind < 75) begin
        str_buf.push_back(8'($urandom_range(8'hC0, 8'hDF)));
        str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 82) begin
        str_buf.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 87) begin
        str_buf.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        repeat (3) str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 94) begin
        str_buf.push_back(8'($urandom_range(1, 255)));
      end else begin
        // Latin lead with an arbitrary second byte
        str_buf.push_back(8'($urandom_range(8'hC3, 8'hC5)));
        str_buf.push_back(8'($urandom_range(1, 255)));
      end
    end
    // tail group cut short by the string end
    if ($urandom_range(0, 99) < 15) begin
      lead = 8'($urandom_range(8'h80, 8'hFF));
      glen = (lead < Lead3Min) ? 2 : (lead < Lead4Min) ? 3 : 4;
      str_buf.push_back(lead);
      repeat ($urandom_range(0, glen - 2)) str_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
    end
    flush_str();
  endtask

  task automatic add_random_text(input int nbytes);
    int start;
    start = text_q.size();
    while (text_q.size() - start < nbytes) emit_string();
  endtask

  // Wait until every byte is sent and every expected byte has come out
  task automatic wait_drained(input int settle);
    while (text_q.size() != 0 || in_valid_i || case_out_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_dir(input logic up);
    @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_upcase_i <= up;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    conv_up = up;
  endtask

  initial begin
    // reset goes low after time zero so the flops see the falling edge
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Upcase: ASCII, Latin-1 pair, y-diaeresis, dotless i, kra, n-apostrophe,
    // division sign, three-byte group, 0xFF lead cut off by the string end
    write_dir(1'b1);
    str_buf = '{8'h7A, 8'h01, 8'hC3, 8'hA0, 8'hC3, 8'hBF, 8'hC4, 8'hB1, 8'hC4, 8'hB8,
                8'hC5, 8'h89, 8'hC3, 8'hB7, 8'hE2, 8'h82, 8'hAC, 8'hFF, 8'h80, 8'hBF};
    flush_str();
    wait_drained(Settle);

    // Downcase: ASCII, Latin-1 pair, Y-diaeresis, multiplication sign,
    // stray continuation byte, n-apostrophe left alone
    write_dir(1'b0);
    str_buf = '{8'h5A, 8'h7F, 8'hC3, 8'h80, 8'hC5, 8'hB8, 8'hC3, 8'h97, 8'h80, 8'h41,
                8'hC5, 8'h89};
    flush_str();
    wait_drained(Settle);

    // Random text, no idling on either side
    write_dir(1'b1);
    calm = 1'b1;
    add_random_text(60);
    wait_drained(Settle);
    calm = 1'b0;

    write_dir(1'b0);
    add_random_text(60);
    wait_drained(Settle);

    // Sender stops with a group open until all results are out
    write_dir(1'b1);
    add_random_text(30);
    text_q.push_back('{b: 8'hC3, last: 1'b0});
    wait_drained(0);
    text_q.push_back('{b: 8'hA9, last: 1'b1});
    add_random_text(30);
    wait_drained(Settle);

    write_dir(1'b0);
    add_random_text(60);
    wait_drained(Settle);

    if (n_err == 0) begin
      $display("utf8_latin_case_converter_core test passed");
    end else begin
      $display("utf8_latin_case_converter_core test failed");
    end
    $finish;
  end

endmodule
